@@ hw/rtl/plce_pkg.sv @@
// Shared types and codes for the piecewise linear curve evaluator.
// Depends on nothing; every other file of the block but plce_ram uses it by scoped names.
package plce_pkg;

    // Operation codes of an input transaction.
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Fixed field widths.
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;
    localparam int PIDX_W  = 4;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 66;
    localparam int SUM_W   = 42;

    // Quotients above this bound always saturate.
    localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(1) << 40;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Input transaction payload.
    typedef struct packed {
        logic                    operation;
        logic [PIDX_W-1:0]       point_index;
        logic signed [VAL_W-1:0] point_x;
        logic signed [VAL_W-1:0] point_y;
        logic signed [VAL_W-1:0] query_pos;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [VAL_W-1:0] curve_value;
        logic                    zero_width_segment;
        logic                    saturated;
    } out_t;

    // Side information that travels with a quotient through the divider.
    typedef struct packed {
        logic                    bypass;
        logic                    zero_seg;
        logic                    neg;
        logic signed [VAL_W-1:0] y0;
    } div_side_t;

endpackage

@@ hw/rtl/plce_ram.sv @@
// Generic RAM with one write port and two registered read ports (read-first).
// Depends on nothing.
module plce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Reads return the contents from before a write at the same edge.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

@@ hw/rtl/plce_divider.sv @@
// Pipelined restoring divider, two quotient bits per stage, with side data.
// Depends on plce_pkg.
module plce_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [plce_pkg::PROD_W-1:0]       in_dividend,
    input  logic [plce_pkg::DIFF_W-1:0]       in_divisor,
    input  plce_pkg::div_side_t               in_side,
    output logic                              out_vld,
    output logic [plce_pkg::PROD_W-1:0]       out_quot,
    output plce_pkg::div_side_t               out_side
);

    localparam int STEPS  = 2;
    localparam int STAGES = plce_pkg::PROD_W / STEPS;
    localparam int REM_W  = plce_pkg::DIFF_W + 1;

    logic [REM_W-1:0]                rem_reg  [STAGES];
    logic [plce_pkg::PROD_W-1:0]     dq_reg   [STAGES];
    logic [plce_pkg::DIFF_W-1:0]     dvs_reg  [STAGES];
    plce_pkg::div_side_t             side_reg [STAGES];
    logic [STAGES-1:0]               vld_reg;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0]            rem_in;
        logic [plce_pkg::PROD_W-1:0] dq_in;
        logic [plce_pkg::DIFF_W-1:0] dvs_in;
        plce_pkg::div_side_t         side_in;
        logic                        vld_in;
        logic [REM_W-1:0]            rem_next;
        logic [plce_pkg::PROD_W-1:0] dq_next;

        // Stage input comes from the previous stage or the divider inputs.
        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign dq_in   = in_dividend;
            assign dvs_in  = in_divisor;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign dq_in   = dq_reg[s-1];
            assign dvs_in  = dvs_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // Shift one dividend bit into the remainder and subtract when it fits.
        always_comb begin
            logic [REM_W-1:0] shifted;
            rem_next = rem_in;
            dq_next  = dq_in;
            for (int k = 0; k < STEPS; k++) begin
                shifted = {rem_next[REM_W-2:0], dq_next[plce_pkg::PROD_W-1]};
                dq_next = {dq_next[plce_pkg::PROD_W-2:0], 1'b0};
                if (shifted >= {1'b0, dvs_in}) begin
                    shifted    = shifted - {1'b0, dvs_in};
                    dq_next[0] = 1'b1;
                end
                rem_next = shifted;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                dq_reg[s]   <= dq_next;
                dvs_reg[s]  <= dvs_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign out_quot = dq_reg[STAGES-1];
    assign out_side = side_reg[STAGES-1];

endmodule

@@ hw/rtl/piecewise_linear_curve_eval.sv @@
// Top level of the piecewise linear curve evaluator: table, segment search,
// difference, multiply, divide and saturate stages. Depends on plce_pkg,
// plce_ram and plce_divider.
//
//  Channel   Ports                      Carries
//  input     s_valid s_ready s_data     load point or evaluate query (in_t)
//  result    m_valid m_ready m_data     value and flags, evaluate only (out_t)
//  config    cfg_wr_en cfg_wr_data      points_in_use
//
// One transaction is accepted per cycle while the result side does not stall; a result
// passes the 33 stages of the divider plus five others after its evaluate transaction.
// Load transactions write the table at acceptance and give no result.
// Reset clears the valid bits and sets points_in_use to 2; the table is
// undefined until loaded. A stall on the result side holds every stage.
module piecewise_linear_curve_eval #(
    parameter int MAX_POINTS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  plce_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output plce_pkg::out_t              m_data,
    input  logic                        cfg_wr_en,
    input  logic [plce_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int VW    = plce_pkg::VAL_W;
    localparam int DW    = plce_pkg::DIFF_W;

    logic adv;
    logic s_acc;

    logic [plce_pkg::CFG_W-1:0] points_reg;
    logic signed [VW-1:0]       x_tab_reg [MAX_POINTS];

    logic [CNT_W-1:0] n_val;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] seg_next;
    logic             load_ok;
    logic [IDX_W-1:0] load_addr;

    logic                 s1_vld_reg;
    logic [IDX_W-1:0]     s1_seg_reg;
    logic                 s1_past_reg;
    logic signed [VW-1:0] s1_t_reg;

    logic                 s2_vld_reg;
    logic                 s2_past_reg;
    logic signed [VW-1:0] s2_t_reg;
    logic [2*VW-1:0]      ram_a;
    logic [2*VW-1:0]      ram_b;

    logic [DW-1:0]        s3_stage_mdy;
    logic [DW-1:0]        s3_stage_mdt;
    logic [DW-1:0]        s3_stage_mdx;
    plce_pkg::div_side_t  s3_stage_side;

    logic                 s3_vld_reg;
    logic [DW-1:0]        s3_mdy_reg;
    logic [DW-1:0]        s3_mdt_reg;
    logic [DW-1:0]        s3_mdx_reg;
    plce_pkg::div_side_t  s3_side_reg;

    logic                          s4_vld_reg;
    logic [plce_pkg::PROD_W-1:0]   s4_prod_reg;
    logic [DW-1:0]                 s4_dvs_reg;
    plce_pkg::div_side_t           s4_side_reg;

    logic                          dv_vld;
    logic [plce_pkg::PROD_W-1:0]   dv_quot;
    plce_pkg::div_side_t           dv_side;

    logic            out_vld_reg;
    plce_pkg::out_t  out_reg;
    plce_pkg::out_t  out_next;

    // Whole pipeline moves unless the result register is full and stalled.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign s_acc   = s_valid && adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= plce_pkg::CFG_W'(2);
        end else if (cfg_wr_en) begin
            points_reg <= cfg_wr_data;
        end
    end

    // Load decode: slots beyond the table are ignored.
    assign load_ok   = s_acc && (s_data.operation == plce_pkg::OP_LOAD) &&
                       (32'(s_data.point_index) < MAX_POINTS);
    assign load_addr = IDX_W'(s_data.point_index);

    // Flip-flop copy of the x column feeds the parallel comparators.
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            x_tab_reg[load_addr] <= s_data.point_x;
        end
    end

    // Clamp the point count and find the segment for the query.
    always_comb begin
        if (32'(points_reg) < 2) begin
            n_val = CNT_W'(2);
        end else if (32'(points_reg) > MAX_POINTS) begin
            n_val = CNT_W'(MAX_POINTS);
        end else begin
            n_val = CNT_W'(points_reg);
        end
        last_idx = IDX_W'(n_val - CNT_W'(1));
        seg_next = last_idx;
        for (int i = MAX_POINTS - 1; i >= 0; i--) begin
            if (i < 32'(n_val) && s_data.query_pos < x_tab_reg[i]) begin
                seg_next = (i == 0) ? '0 : IDX_W'(i - 1);
            end
        end
    end

    // Stage 1: segment index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid && (s_data.operation == plce_pkg::OP_EVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_seg_reg  <= seg_next;
            s1_past_reg <= (seg_next == last_idx);
            s1_t_reg    <= s_data.query_pos;
        end
    end

    // Point table, read at the segment start and end.
    plce_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .aclk      (aclk),
        .wr_en     (load_ok),
        .wr_addr   (load_addr),
        .wr_data   ({s_data.point_x, s_data.point_y}),
        .rd_en     (adv),
        .rd_addr_a (s1_seg_reg),
        .rd_addr_b (s1_seg_reg + IDX_W'(1)),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // Stage 2: table data arrives with the query.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_past_reg <= s1_past_reg;
            s2_t_reg    <= s1_t_reg;
        end
    end

    // Stage 3: differences, their magnitudes and the result sign.
    always_comb begin
        logic signed [VW-1:0] x0, y0, x1, y1;
        logic [DW-1:0] dy, dt, dx;
        x0 = ram_a[2*VW-1:VW];
        y0 = ram_a[VW-1:0];
        x1 = ram_b[2*VW-1:VW];
        y1 = ram_b[VW-1:0];
        dy = {y1[VW-1], y1} - {y0[VW-1], y0};
        dt = {s2_t_reg[VW-1], s2_t_reg} - {x0[VW-1], x0};
        dx = {x1[VW-1], x1} - {x0[VW-1], x0};
        s3_stage_mdy  = dy[DW-1] ? (~dy + DW'(1)) : dy;
        s3_stage_mdt  = dt[DW-1] ? (~dt + DW'(1)) : dt;
        s3_stage_mdx  = dx[DW-1] ? (~dx + DW'(1)) : dx;
        s3_stage_side.zero_seg = !s2_past_reg && (x1 == x0);
        s3_stage_side.bypass   = s2_past_reg || (x1 == x0);
        s3_stage_side.neg      = dy[DW-1] ^ dt[DW-1] ^ dx[DW-1];
        s3_stage_side.y0       = y0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_mdy_reg  <= s3_stage_mdy;
            s3_mdt_reg  <= s3_stage_mdt;
            s3_mdx_reg  <= s3_stage_mdx;
            s3_side_reg <= s3_stage_side;
        end
    end

    // Stage 4: exact product of the magnitudes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (adv) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_prod_reg <= plce_pkg::PROD_W'(s3_mdy_reg) * plce_pkg::PROD_W'(s3_mdt_reg);
            s4_dvs_reg  <= s3_mdx_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // Quotient truncated toward zero.
    plce_divider u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_vld      (s4_vld_reg),
        .in_dividend (s4_prod_reg),
        .in_divisor  (s4_dvs_reg),
        .in_side     (s4_side_reg),
        .out_vld     (dv_vld),
        .out_quot    (dv_quot),
        .out_side    (dv_side)
    );

    // Final stage: apply sign, add the left y and saturate.
    always_comb begin
        logic [plce_pkg::SUM_W-1:0]        q_mag;
        logic [plce_pkg::SUM_W-1:0]        q_sgn;
        logic signed [plce_pkg::SUM_W-1:0] sum;
        q_mag = dv_quot[plce_pkg::SUM_W-1:0];
        q_sgn = dv_side.neg ? (~q_mag + plce_pkg::SUM_W'(1)) : q_mag;
        sum   = $signed({{(plce_pkg::SUM_W - VW){dv_side.y0[VW-1]}}, dv_side.y0}) +
                $signed(q_sgn);
        out_next.zero_width_segment = dv_side.zero_seg;
        out_next.saturated          = 1'b0;
        out_next.curve_value        = dv_side.y0;
        if (!dv_side.bypass) begin
            if (dv_quot > plce_pkg::Q_LIMIT) begin
                out_next.saturated   = 1'b1;
                out_next.curve_value = dv_side.neg ? plce_pkg::VAL_MIN : plce_pkg::VAL_MAX;
            end else if (sum > plce_pkg::SUM_W'(plce_pkg::VAL_MAX)) begin
                out_next.saturated   = 1'b1;
                out_next.curve_value = plce_pkg::VAL_MAX;
            end else if (sum < $signed({{(plce_pkg::SUM_W - VW){1'b1}}, plce_pkg::VAL_MIN}))
            begin
                out_next.saturated   = 1'b1;
                out_next.curve_value = plce_pkg::VAL_MIN;
            end else begin
                out_next.curve_value = sum[VW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/plce_checker.sv @@
// Port-level checks for the piecewise linear curve evaluator and its bind.
// Depends on plce_pkg and the top level piecewise_linear_curve_eval.
module plce_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input plce_pkg::out_t m_data
);

    // No result is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Input is taken exactly when the result side can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow result side");

    // A clipped value sits at a range limit and never on a zero-width segment.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
        !m_data.zero_width_segment &&
        (m_data.curve_value == plce_pkg::VAL_MAX || m_data.curve_value == plce_pkg::VAL_MIN))
        else $error("saturated flag inconsistent with value");

endmodule

bind piecewise_linear_curve_eval plce_checker u_plce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/piecewise_linear_curve_eval_checker.sv @@
// Checker for the piecewise linear curve evaluator: watches the input, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on plce_pkg for the payload types and operation codes.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  plce_pkg::in_t               s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  plce_pkg::out_t              m_data,
    input  logic                        cfg_wr_en,
    input  logic [plce_pkg::CFG_W-1:0]  cfg_wr_data,
    output int                          errors,
    output int                          pending
);

    localparam int TABLE_DEPTH = 16;

    logic signed [plce_pkg::VAL_W-1:0] ctrl_x [TABLE_DEPTH];
    logic signed [plce_pkg::VAL_W-1:0] ctrl_y [TABLE_DEPTH];
    logic [plce_pkg::CFG_W-1:0]        active_points;
    plce_pkg::out_t                    expected_values [$];

    function automatic longint magnitude(longint d);
        return (d < 0) ? -d : d;
    endfunction

    // Segment search, exact interpolation and saturation of one query.
    function automatic plce_pkg::out_t eval_curve(logic signed [plce_pkg::VAL_W-1:0] t);
        int             n;
        int             seg;
        longint         x0, y0, x1, y1, dy, dt, dx, q, sum;
        logic [127:0]   prod, quo;
        bit             neg;
        plce_pkg::out_t r;
        n = active_points;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        seg = n - 1;
        for (int i = 0; i < n; i++) begin
            if (longint'(t) < longint'(ctrl_x[i])) begin
                seg = (i == 0) ? 0 : i - 1;
                break;
            end
        end
        r = '0;
        // At or past the last point the last y is returned unchanged.
        if (seg == n - 1) begin
            r.curve_value = ctrl_y[n-1];
            return r;
        end
        x0 = ctrl_x[seg];
        y0 = ctrl_y[seg];
        x1 = ctrl_x[seg+1];
        y1 = ctrl_y[seg+1];
        // A segment of zero width gives its left y and raises the flag.
        if (x1 == x0) begin
            r.curve_value = ctrl_y[seg];
            r.zero_width_segment = 1'b1;
            return r;
        end
        dy = y1 - y0;
        dt = longint'(t) - x0;
        dx = x1 - x0;
        neg = (dy < 0) != (dt < 0);
        if (dx < 0) neg = !neg;
        prod = 128'(magnitude(dy)) * 128'(magnitude(dt));
        quo = prod / 128'(magnitude(dx));
        if (quo > (128'(1) << 40)) begin
            sum = neg ? -64'sh8000_0001 : 64'sh8000_0000;
        end else begin
            q = longint'(quo[63:0]);
            sum = neg ? y0 - q : y0 + q;
        end
        if (sum > 64'sh7FFF_FFFF) begin
            sum = 64'sh7FFF_FFFF;
            r.saturated = 1'b1;
        end
        if (sum < -64'sh8000_0000) begin
            sum = -64'sh8000_0000;
            r.saturated = 1'b1;
        end
        r.curve_value = sum[plce_pkg::VAL_W-1:0];
        return r;
    endfunction

    // Track configuration and table, queue predictions, compare results.
    always @(posedge aclk) begin
        plce_pkg::out_t exp_r;
        if (!aresetn) begin
            active_points = 5'd2;
            expected_values.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result transaction: value %h zw %b sat %b",
                                 m_data.curve_value, m_data.zero_width_segment,
                                 m_data.saturated);
                end else begin
                    exp_r = expected_values.pop_front();
                    if (m_data.curve_value !== exp_r.curve_value ||
                        m_data.zero_width_segment !== exp_r.zero_width_segment ||
                        m_data.saturated !== exp_r.saturated) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                                     exp_r.curve_value, exp_r.zero_width_segment,
                                     exp_r.saturated, m_data.curve_value,
                                     m_data.zero_width_segment, m_data.saturated);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.operation == plce_pkg::OP_LOAD) begin
                    ctrl_x[s_data.point_index] = s_data.point_x;
                    ctrl_y[s_data.point_index] = s_data.point_y;
                end else begin
                    expected_values.insert(expected_values.size(),
                                           eval_curve(s_data.query_pos));
                end
            end
            if (cfg_wr_en)
                active_points = cfg_wr_data;
            pending <= expected_values.size();
        end
    end

endmodule

@@ verif/piecewise_linear_curve_eval_tb.sv @@
// Testbench top for the piecewise linear curve evaluator: clock, reset, stimulus
// and verdict. Depends on plce_pkg, the block and piecewise_linear_curve_eval_checker.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 45;
    localparam int ITEM_TARGET  = 1150;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    plce_pkg::in_t              s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    plce_pkg::out_t             m_data;
    logic                       cfg_wr_en = 1'b0;
    logic [plce_pkg::CFG_W-1:0] cfg_wr_data = '0;
    int                         errors;
    int                         pending;
    int                         cycles = 0;
    int                         items_sent = 0;
    bit                         quiet = 1'b0;
    int                         stall_left = 0;
    logic signed [31:0]         table_x [16];

    piecewise_linear_curve_eval u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    piecewise_linear_curve_eval_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Send one transaction, with an optional idle burst in front of it.
    task automatic send_item(plce_pkg::in_t item);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic load_point(int idx, logic signed [31:0] x, logic signed [31:0] y);
        plce_pkg::in_t it;
        it.operation   = plce_pkg::OP_LOAD;
        it.point_index = idx[3:0];
        it.point_x     = x;
        it.point_y     = y;
        it.query_pos   = $urandom;
        table_x[idx]   = x;
        send_item(it);
    endtask

    task automatic eval_at(logic signed [31:0] t);
        plce_pkg::in_t it;
        it.operation   = plce_pkg::OP_EVAL;
        it.point_index = plce_pkg::PIDX_W'($urandom);
        it.point_x     = $urandom;
        it.point_y     = $urandom;
        it.query_pos   = t;
        send_item(it);
    endtask

    // Stop sending, wait for every result, then let the pipeline run dry.
    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_points(logic [plce_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Load all slots with a table of a random shape.
    task automatic load_table;
        logic signed [31:0] xs [16];
        logic signed [31:0] tmp;
        int mode, step_max;
        mode = $urandom_range(0, 3);
        step_max = (1 << $urandom_range(0, 24));
        xs[0] = $urandom;
        if (mode == 1) xs[0] = $signed($urandom_range(0, 2000)) - 1000;
        for (int i = 1; i < 16; i++) begin
            if (mode == 0 || mode == 2) xs[i] = $urandom;
            else if (mode == 3 && $urandom_range(0, 2) == 0) xs[i] = xs[i-1];
            else xs[i] = xs[i-1] + $signed($urandom_range(0, step_max));
        end
        // Mode 0 full range tables are sorted; mode 2 stays unsorted.
        if (mode == 0) begin
            for (int i = 1; i < 16; i++)
                for (int j = i; j > 0 && xs[j] < xs[j-1]; j--) begin
                    tmp = xs[j];
                    xs[j] = xs[j-1];
                    xs[j-1] = tmp;
                end
        end
        for (int i = 0; i < 16; i++)
            load_point(i, xs[i], $urandom_range(0, 1) ? $urandom
                                 : $signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endtask

    // Query mostly near control points, sometimes anywhere or at the extremes.
    task automatic random_query;
        int sel;
        logic signed [31:0] t;
        sel = $urandom_range(0, 9);
        if (sel < 2) t = $urandom;
        else if (sel == 2) t = $urandom_range(0, 1) ? plce_pkg::VAL_MAX : plce_pkg::VAL_MIN;
        else if (sel == 3) t = table_x[$urandom_range(0, 15)];
        else t = table_x[$urandom_range(0, 15)] + $signed($urandom_range(0, 1 << 18))
                 - (1 << 17);
        eval_at(t);
    endtask

    initial begin
        int cfg_pick [8] = '{2, 16, 0, 1, 31, 17, 8, 3};
        int phase;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: evenly spread table over the full range whose first segment
        // has zero width, with alternating extreme values.
        write_points(plce_pkg::CFG_W'(16));
        for (int i = 0; i < 16; i++)
            load_point(i, (i == 0) ? -(7 << 28) : (i - 8) * (1 << 28),
                       (i % 2) ? plce_pkg::VAL_MAX : plce_pkg::VAL_MIN);
        eval_at(plce_pkg::VAL_MIN);
        eval_at(plce_pkg::VAL_MAX);
        eval_at(-(2 << 28));
        eval_at(32'sh0800_0000);
        eval_at(32'sh0000_0000);
        eval_at(32'sh7000_0000);
        drain();

        // Random phases, each with its own register value and table.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 150) quiet = 1'b1;
            write_points(plce_pkg::CFG_W'((phase < 8) ? cfg_pick[phase]
                                                      : $urandom_range(2, 16)));
            load_table();
            repeat (70) begin
                if ($urandom_range(0, 6) == 0)
                    load_point($urandom_range(0, 15), $urandom, $urandom);
                else
                    random_query();
            end
            drain();
            phase++;
        end

        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
